// File: sv/round_robin_process_scheduler_core_assert.svh
// Assertion macros for the round-robin process scheduler checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RRPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RRPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rrps_pkg.sv
// Shared types and constants of the round-robin process scheduler.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package rrps_pkg;

    localparam int TGT_W      = 4;
    localparam int STAT_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int PID_W      = 5;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_CREATE    = 2'd0,
        CMD_TERMINATE = 2'd1,
        CMD_SCHEDULE  = 2'd2,
        CMD_UNUSED    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_CREATED    = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_TERMINATED = 3'd2,
        STAT_BAD_SLOT   = 3'd3,
        STAT_SCHEDULED  = 3'd4,
        STAT_NO_PROC    = 3'd5,
        STAT_NONE_READY = 3'd6
    } t_status;

    // Per-slot process state as stored in the slot table.
    typedef enum logic [1:0] {
        PS_READY      = 2'd0,
        PS_RUNNING    = 2'd1,
        PS_TERMINATED = 2'd2
    } t_pstate;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_COUNT,
        SRC_TARGET,
        SRC_SCAN
    } t_slot_src;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SCAN,
        ST_DEMOTE,
        ST_RESP
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic      latch_in;
        logic      create;
        logic      terminate;
        logic      scan_load;
        logic      scan_fill;
        logic      scan_step;
        logic      found;
        logic      demote;
        logic      set_res;
        t_status   res_code;
        t_slot_src res_src;
        logic      load_out;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic target_ok;
        logic probe_ready;
        logic last_probe;
        logic demote_needed;
        logic out_free;
    } t_dp_stat;

endpackage

// File: sv/round_robin_process_scheduler_core.sv
// Top level of the round-robin process scheduler.
// Depends on rrps_pkg, rrps_ctrl and rrps_dp.
//
// Usage:
//   Slave stream carries one command transaction: create a slot, terminate
//   a slot, or schedule the next ready slot. Master stream returns exactly
//   one result transaction per command (status, slot, pid).
//   Commands are handled one at a time; the slave side is ready only while
//   the sequencer is idle, which includes while an earlier result still
//   waits in the output register.
// Sequence (accept to result valid):
//   create, terminate, a bad command and an empty-table schedule pass
//   ST_EXEC and then ST_RESP. schedule passes ST_EXEC, ST_FILL, ST_SCAN
//   for k probed slots (k = 1..count), ST_DEMOTE when the previously
//   running slot is returned to ready, then ST_RESP. A full circle with no
//   ready slot probes count slots. The scan probes one slot per cycle
//   through the single read port of the slot table.
// Overlap: the slave side is ready again in the cycle after the result loads;
//   a new command is never taken before the previous result has loaded.
// Reset (synchronous, active low): count, scan position and running record
//   clear; the slot table is not cleared, it is filled by create commands.
// Stall: when the receiver holds tready low the result stays valid and
//   stable; the sequencer waits with the next result until the register frees.
module round_robin_process_scheduler_core #(
    parameter int SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [1:0] cmd, [5:2] target_slot, [7:6] zero
    input  logic [rrps_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [2:0] status, [6:3] slot, [11:7] pid, [15:12] zero
    output logic [rrps_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import rrps_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: one command at a time, scan runs one probe per cycle
    rrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    // slot table, scheduler registers and output register
    rrps_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// File: sv/rrps_ctrl.sv
// Sequencer of the round-robin process scheduler.
// Depends on rrps_pkg; drives the datapath through t_dp_cmd and reads t_dp_stat.
module rrps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output rrps_pkg::t_dp_cmd o_cmd,
    input  rrps_pkg::t_dp_stat i_stat
);
    import rrps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.res_code   = STAT_CREATED;
        o_cmd.res_src    = SRC_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RESP;
                unique case (i_stat.cmd)
                    CMD_CREATE: begin
                        o_cmd.set_res = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.res_code = STAT_FULL;
                        end else begin
                            o_cmd.create   = 1'b1;
                            o_cmd.res_code = STAT_CREATED;
                            o_cmd.res_src  = SRC_COUNT;
                        end
                    end
                    CMD_TERMINATE: begin
                        o_cmd.set_res = 1'b1;
                        if (i_stat.target_ok) begin
                            o_cmd.terminate = 1'b1;
                            o_cmd.res_code  = STAT_TERMINATED;
                            o_cmd.res_src   = SRC_TARGET;
                        end else begin
                            o_cmd.res_code = STAT_BAD_SLOT;
                        end
                    end
                    CMD_SCHEDULE: begin
                        if (i_stat.empty) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = STAT_NO_PROC;
                        end else begin
                            o_cmd.scan_load = 1'b1;
                            n_state         = ST_FILL;
                        end
                    end
                    default: begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = STAT_BAD_SLOT;
                    end
                endcase
            end
            ST_FILL: begin
                // prime the table read pipeline
                o_cmd.scan_fill = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                priority if (i_stat.probe_ready) begin
                    o_cmd.found    = 1'b1;
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = STAT_SCHEDULED;
                    o_cmd.res_src  = SRC_SCAN;
                    n_state        = i_stat.demote_needed ? ST_DEMOTE : ST_RESP;
                end else if (i_stat.last_probe) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = STAT_NONE_READY;
                    n_state        = ST_RESP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DEMOTE: begin
                o_cmd.demote = 1'b1;
                n_state      = ST_RESP;
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rrps_dp.sv
// Datapath of the round-robin process scheduler: slot table, counters,
// running-slot record, result and output registers. Depends on rrps_pkg.
module rrps_dp #(
    parameter int SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [rrps_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [rrps_pkg::OUT_DATA_W-1:0]  o_out_data,
    input  rrps_pkg::t_dp_cmd                i_cmd,
    output rrps_pkg::t_dp_stat               o_stat
);
    import rrps_pkg::*;

    localparam int IW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > TGT_W) ? CW : TGT_W;

    // slot table, no reset: entries below the count are always written first
    logic [1:0]        r_mem [SLOTS];
    logic [1:0]        r_rd_data;

    t_cmd              r_cmd;
    logic [TGT_W-1:0]  r_tgt;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_scan;
    logic              r_run_valid;
    logic              r_run_live;
    logic [IW-1:0]     r_run_slot;
    logic [IW-1:0]     r_old_slot;

    logic [IW-1:0]     r_pos;
    logic [IW-1:0]     r_cpos;
    logic [CW-1:0]     r_left;

    t_status           r_res_status;
    logic [IW-1:0]     r_res_slot;
    logic              r_res_has;

    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [1:0]        wr_data;
    logic [IW-1:0]     tgt_idx;
    logic [IW-1:0]     pos_next;
    logic [IW-1:0]     scan_start;
    logic [IW-1:0]     res_slot_sel;
    logic [SLOT_W-1:0] out_slot;
    logic [PID_W-1:0]  out_pid;

    assign tgt_idx    = IW'(r_tgt);
    assign pos_next   = ((CW'(r_pos) + CW'(1)) >= r_count) ? '0 : r_pos + IW'(1);
    assign scan_start = (CW'(r_scan) >= r_count) ? '0 : r_scan;

    // table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = PS_READY;
        priority if (i_cmd.create) begin
            wr_en   = 1'b1;
            wr_addr = IW'(r_count);
            wr_data = PS_READY;
        end else if (i_cmd.terminate) begin
            wr_en   = 1'b1;
            wr_addr = tgt_idx;
            wr_data = PS_TERMINATED;
        end else if (i_cmd.found) begin
            wr_en   = 1'b1;
            wr_addr = r_cpos;
            wr_data = PS_RUNNING;
        end else if (i_cmd.demote) begin
            wr_en   = 1'b1;
            wr_addr = r_old_slot;
            wr_data = PS_READY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_pos];
    end

    // input capture and scan walker
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd <= t_cmd'(i_in_data[1:0]);
            r_tgt <= i_in_data[TGT_W+1:2];
        end
        if (i_cmd.scan_load) begin
            r_pos  <= scan_start;
            r_left <= r_count;
        end else if (i_cmd.scan_fill || i_cmd.scan_step) begin
            r_cpos <= r_pos;
            r_pos  <= pos_next;
            if (i_cmd.scan_step) begin
                r_left <= r_left - CW'(1);
            end
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan      <= '0;
            r_run_valid <= 1'b0;
            r_run_live  <= 1'b0;
            r_run_slot  <= '0;
        end else begin
            if (i_cmd.create) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.terminate && (tgt_idx == r_run_slot)) begin
                r_run_live <= 1'b0;
            end
            if (i_cmd.found) begin
                r_run_slot  <= r_cpos;
                r_run_valid <= 1'b1;
                r_run_live  <= 1'b1;
                r_scan      <= r_cpos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.found) begin
            r_old_slot <= r_run_slot;
        end
    end

    // result capture
    always_comb begin
        unique case (i_cmd.res_src)
            SRC_COUNT:  res_slot_sel = IW'(r_count);
            SRC_TARGET: res_slot_sel = tgt_idx;
            SRC_SCAN:   res_slot_sel = r_cpos;
            default:    res_slot_sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            r_res_slot   <= res_slot_sel;
            r_res_has    <= (i_cmd.res_src != SRC_NONE);
        end
    end

    assign out_slot = SLOT_W'(r_res_slot);
    assign out_pid  = r_res_has ? (PID_W'(r_res_slot) + PID_W'(1)) : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {(OUT_DATA_W - STAT_W - SLOT_W - PID_W)'(0),
                           out_pid, out_slot, r_res_status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_stat               = '0;
        o_stat.cmd           = r_cmd;
        o_stat.full          = (r_count == CW'(SLOTS));
        o_stat.empty         = (r_count == '0);
        o_stat.target_ok     = (CMPW'(r_tgt) < CMPW'(r_count));
        o_stat.probe_ready   = (r_rd_data == PS_READY);
        o_stat.last_probe    = (r_left == CW'(1));
        o_stat.demote_needed = r_run_valid && r_run_live;
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

endmodule

// File: sv/rrps_checker.sv
// Port-level checker of the round-robin process scheduler, bound to the top level.
// Depends on rrps_pkg and round_robin_process_scheduler_core_assert.svh.
`include "round_robin_process_scheduler_core_assert.svh"

module rrps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [rrps_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [rrps_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import rrps_pkg::*;

    logic       in_acc;
    logic [2:0] st;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign st     = o_m_axis_tdata[2:0];

    // hold a stalled result
    `RRPS_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // one command in flight: no second transaction right after an accept
    `RRPS_ASSERT_NXT(a_busy_after_acc, in_acc, !o_s_axis_tready,
        "ready stayed high after accept")

    // no result can appear in the cycle after an accept
    `RRPS_ASSERT_NXT(a_min_latency, in_acc, !$rose(o_m_axis_tvalid),
        "result too early")

    `RRPS_ASSERT_IMP(a_status_code, o_m_axis_tvalid, st != 3'd7,
        "unknown status code")

    // statuses without a slot carry zero slot and pid
    `RRPS_ASSERT_IMP(a_no_slot_zero,
        o_m_axis_tvalid && (st == STAT_FULL || st == STAT_BAD_SLOT ||
        st == STAT_NO_PROC || st == STAT_NONE_READY),
        o_m_axis_tdata[11:3] == 9'd0, "slot or pid set without a slot")

endmodule

bind round_robin_process_scheduler_core rrps_checker u_rrps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
